### rtl/core/assert_macros.svh
// Assertion helpers used by the checker in bdq_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define BDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a rising edge outside reset.
`define BDQ_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/core/bdq_pkg.sv
`timescale 1ns / 1ps

package bdq_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int CMD_FIFO_DEPTH   = 2;

    localparam logic [1:0] ACT_PUSH_FRONT = 2'd0;
    localparam logic [1:0] ACT_PUSH_BACK  = 2'd1;
    localparam logic [1:0] ACT_POP_FRONT  = 2'd2;
    localparam logic [1:0] ACT_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Memory operation that the back part carries out for one item.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] push_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pop_value;
        logic [1:0]         status;
        logic [5:0]         occupancy;
    } result_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] value;
        logic [1:0]  status;
        logic [5:0]  occupancy;
    } cmd_t;

endpackage

### rtl/core/bdq_front.sv
`timescale 1ns / 1ps

module bdq_front #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  bdq_pkg::item_t                item,
    output logic                          cmd_push,
    output bdq_pkg::cmd_t                 cmd,
    output logic [$clog2(CAPACITY)-1:0]   cmd_addr,
    input  logic                          cmd_full
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             is_push;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] front_dec;
    logic [IDX_W-1:0] front_inc;
    logic [SUM_W-1:0] tail_sum;
    logic [SUM_W-1:0] last_sum;
    logic [IDX_W-1:0] tail_pos;
    logic [IDX_W-1:0] last_pos;

    assign item_stall = cmd_full;
    assign accept     = item_valid && !item_stall;
    assign cmd_push   = accept;

    assign is_push = (item.action == bdq_pkg::ACT_PUSH_FRONT)
                  || (item.action == bdq_pkg::ACT_PUSH_BACK);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    assign front_dec = (front_reg == '0) ? IDX_W'(CAPACITY - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == IDX_W'(CAPACITY - 1)) ? '0 : front_reg + 1'b1;

    // The sum of front and count stays below twice the capacity, so one
    // compare and subtract brings it back into the ring.
    assign tail_sum = SUM_W'(front_reg) + SUM_W'(count_reg);
    assign last_sum = tail_sum - 1'b1;
    assign tail_pos = (tail_sum >= SUM_W'(CAPACITY)) ? IDX_W'(tail_sum - SUM_W'(CAPACITY))
                                                      : IDX_W'(tail_sum);
    assign last_pos = (last_sum >= SUM_W'(CAPACITY)) ? IDX_W'(last_sum - SUM_W'(CAPACITY))
                                                      : IDX_W'(last_sum);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        cmd.op     = bdq_pkg::OP_NONE;
        cmd.value  = item.push_value;
        cmd.status = bdq_pkg::ST_DONE;
        cmd_addr   = front_reg;
        if (is_push)
        begin
            if (full)
            begin
                cmd.status = bdq_pkg::ST_FULL;
            end
            else
            begin
                cmd.op     = bdq_pkg::OP_WRITE;
                count_next = count_reg + 1'b1;
                if (item.action == bdq_pkg::ACT_PUSH_FRONT)
                begin
                    front_next = front_dec;
                    cmd_addr   = front_dec;
                end
                else
                begin
                    cmd_addr = tail_pos;
                end
            end
        end
        else
        begin
            if (empty)
            begin
                cmd.status = bdq_pkg::ST_EMPTY;
            end
            else
            begin
                cmd.op     = bdq_pkg::OP_READ;
                count_next = count_reg - 1'b1;
                if (item.action == bdq_pkg::ACT_POP_FRONT)
                begin
                    front_next = front_inc;
                    cmd_addr   = front_reg;
                end
                else
                begin
                    cmd_addr = last_pos;
                end
            end
        end
        cmd.occupancy = 6'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

### rtl/core/bdq_cmd_fifo.sv
`timescale 1ns / 1ps

module bdq_cmd_fifo #(
    parameter int ADDR_W = $clog2(bdq_pkg::DEFAULT_CAPACITY)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bdq_pkg::cmd_t       push_cmd,
    input  logic [ADDR_W-1:0]   push_addr,
    output logic                full,
    input  logic                pop,
    output logic                nonempty,
    output bdq_pkg::cmd_t       head_cmd,
    output logic [ADDR_W-1:0]   head_addr
);

    localparam int DEPTH = bdq_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdq_pkg::cmd_t     cmd_mem  [DEPTH];
    logic [ADDR_W-1:0] addr_mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign nonempty  = (fill_reg != '0);
    assign head_cmd  = cmd_mem[rd_ptr_reg];
    assign head_addr = addr_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            addr_mem[wr_ptr_reg] <= push_addr;
        end
    end

endmodule

### rtl/core/bdq_back.sv
`timescale 1ns / 1ps

module bdq_back #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_nonempty,
    input  bdq_pkg::cmd_t                 cmd,
    input  logic [$clog2(CAPACITY)-1:0]   cmd_addr,
    output logic                          cmd_pop,
    output logic                          result_valid,
    input  logic                          result_stall,
    output bdq_pkg::result_t              result
);

    logic [31:0] word_store [CAPACITY];

    logic        res_valid_reg;
    logic        res_read_reg;
    logic [1:0]  res_status_reg;
    logic [5:0]  res_occ_reg;
    logic [31:0] rd_data_reg;

    // A command is issued only when the result register is free or being
    // taken, so a stalled result never sees its read data replaced.
    assign cmd_pop = cmd_nonempty && (!res_valid_reg || !result_stall);

    assign result_valid     = res_valid_reg;
    assign result.pop_value = res_read_reg ? rd_data_reg : '0;
    assign result.status    = res_status_reg;
    assign result.occupancy = res_occ_reg;

    always_ff @(posedge clk)
    begin
        if (cmd_pop && (cmd.op == bdq_pkg::OP_WRITE))
        begin
            word_store[cmd_addr] <= cmd.value;
        end
        if (cmd_pop && (cmd.op == bdq_pkg::OP_READ))
        begin
            rd_data_reg <= word_store[cmd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_read_reg   <= (cmd.op == bdq_pkg::OP_READ);
            res_status_reg <= cmd.status;
            res_occ_reg    <= cmd.occupancy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

endmodule

### rtl/core/bounded_deque.sv
`timescale 1ns / 1ps
// An item's command goes into the command queue at its transfer and then into
// the result register, so a result never transfers along with its own item.
// One item per cycle while item_stall is low; the front updates the ring
// bookkeeping and the back makes one access to the single-port word store.
// Reset clears the front index, the word count and all valid flags at once;
// the word store is not cleared and no clearing pass runs.

module bounded_deque #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  bdq_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output bdq_pkg::result_t result
);

    localparam int ADDR_W = $clog2(CAPACITY);

    logic              fe_push;
    bdq_pkg::cmd_t     fe_cmd;
    logic [ADDR_W-1:0] fe_addr;
    logic              q_full;
    logic              q_nonempty;
    logic              q_pop;
    bdq_pkg::cmd_t     q_cmd;
    logic [ADDR_W-1:0] q_addr;

    bdq_front #(
        .CAPACITY (CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cmd_push   (fe_push),
        .cmd        (fe_cmd),
        .cmd_addr   (fe_addr),
        .cmd_full   (q_full)
    );

    bdq_cmd_fifo #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fe_push),
        .push_cmd  (fe_cmd),
        .push_addr (fe_addr),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .head_cmd  (q_cmd),
        .head_addr (q_addr)
    );

    bdq_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_nonempty (q_nonempty),
        .cmd          (q_cmd),
        .cmd_addr     (q_addr),
        .cmd_pop      (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

### rtl/core/bdq_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker #(
    parameter int CAPACITY = bdq_pkg::DEFAULT_CAPACITY
) (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_stall,
    input bdq_pkg::result_t result
);

    // A refused action never removes a word.
    `BDQ_ASSERT(a_fail_zero, clk, rst_n,
        (result_valid && (result.status != bdq_pkg::ST_DONE)) |-> (result.pop_value == '0),
        "failed action returned a non-zero word")

    // A push is refused only when the deque holds its full capacity.
    `BDQ_ASSERT(a_full_occ, clk, rst_n,
        (result_valid && (result.status == bdq_pkg::ST_FULL))
            |-> (result.occupancy == 6'(CAPACITY)),
        "full status with occupancy below capacity")

    // A pop is refused only when nothing is held.
    `BDQ_ASSERT(a_empty_occ, clk, rst_n,
        (result_valid && (result.status == bdq_pkg::ST_EMPTY)) |-> (result.occupancy == '0),
        "empty status with words held")

    `BDQ_NEVER(a_occ_range, clk, rst_n,
        result_valid && (CAPACITY < 64) && (result.occupancy > 6'(CAPACITY)),
        "occupancy beyond capacity")

    `BDQ_ASSERT(a_hold, clk, rst_n,
        (result_valid && result_stall) |=> (result_valid && $stable(result)),
        "stalled result changed")

endmodule

bind bounded_deque bdq_checker #(.CAPACITY(CAPACITY)) u_checker (.*);

### bench/deque_checker.sv
`timescale 1ns / 1ps

module deque_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  bdq_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  bdq_pkg::result_t result,
    output int               failures,
    output int               pending
);

    localparam int DEPTH = bdq_pkg::DEFAULT_CAPACITY;

    logic [31:0]      ring [DEPTH];
    int               head;
    int               held;
    bdq_pkg::result_t expected_results [$];

    // Applies one action to the shadow ring and returns the result it should give.
    function automatic bdq_pkg::result_t apply_action(bdq_pkg::item_t it);
        bdq_pkg::result_t r;
        r.pop_value = '0;
        r.status    = bdq_pkg::ST_DONE;
        if (it.action == bdq_pkg::ACT_PUSH_FRONT || it.action == bdq_pkg::ACT_PUSH_BACK)
        begin
            if (held >= DEPTH)
            begin
                r.status = bdq_pkg::ST_FULL;
            end
            else if (it.action == bdq_pkg::ACT_PUSH_FRONT)
            begin
                head       = (head + DEPTH - 1) % DEPTH;
                ring[head] = it.push_value;
                held++;
            end
            else
            begin
                ring[(head + held) % DEPTH] = it.push_value;
                held++;
            end
        end
        else
        begin
            if (held == 0)
            begin
                r.status = bdq_pkg::ST_EMPTY;
            end
            else if (it.action == bdq_pkg::ACT_POP_FRONT)
            begin
                r.pop_value = ring[head];
                head        = (head + 1) % DEPTH;
                held--;
            end
            else
            begin
                r.pop_value = ring[(head + held - 1) % DEPTH];
                held--;
            end
        end
        r.occupancy = 6'(held);
        return r;
    endfunction

    task automatic report_failure(string msg);
        $display("deque_checker: %0t: %s", $realtime, msg);
        failures++;
    endtask

    always @(posedge clk)
    begin
        bdq_pkg::result_t want;
        if (!rst_n)
        begin
            head = 0;
            held = 0;
            expected_results.delete();
        end
        else
        begin
            // A result never transfers at the same edge as its own item, so the result
            // transfer is checked before this edge's item is predicted.
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_failure($sformatf("result %h with nothing outstanding", result));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.pop_value !== want.pop_value)
                        report_failure($sformatf("pop_value %h, predicted %h",
                                                 result.pop_value, want.pop_value));
                    if (result.status !== want.status)
                        report_failure($sformatf("status %0d, predicted %0d",
                                                 result.status, want.status));
                    if (result.occupancy !== want.occupancy)
                        report_failure($sformatf("occupancy %0d, predicted %0d",
                                                 result.occupancy, want.occupancy));
                end
            end
            if (item_valid && !item_stall)
                expected_results.push_back(apply_action(item));
        end
        pending = expected_results.size();
    end

endmodule

### bench/bounded_deque_tb.sv
`timescale 1ns / 1ps

module bounded_deque_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    bdq_pkg::item_t   item;
    logic             result_valid;
    logic             result_stall = 1'b0;
    bdq_pkg::result_t result;
    int               failures;
    int               pending;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               cycles = 0;

    bounded_deque dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    deque_checker deque_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bounded_deque_tb: errors");
            $finish;
        end
    end

    always @(negedge clk)
        result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);

    // Extreme words turn up often so that sign and carry edges are exercised.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(logic [1:0] act, logic [31:0] value);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid      <= 1'b1;
        item.action     <= act;
        item.push_value <= value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Runs of push-heavy, pop-heavy and balanced traffic carry the deque to full and back to empty.
    task automatic send_random(int count);
        int         sent;
        int         push_pct;
        int         run;
        logic [1:0] act;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            run = $urandom_range(70, 20);
            for (int i = 0; i < run && sent < count; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    act = $urandom_range(1) ? bdq_pkg::ACT_PUSH_BACK : bdq_pkg::ACT_PUSH_FRONT;
                else
                    act = $urandom_range(1) ? bdq_pkg::ACT_POP_BACK : bdq_pkg::ACT_POP_FRONT;
                send_item(act, rand_word());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 12;
        stall_pct     = 53;

        // Pops on an empty deque; the value field should be ignored.
        send_item(bdq_pkg::ACT_POP_FRONT, 32'hdead_beef);
        send_item(bdq_pkg::ACT_POP_BACK, 32'hffff_ffff);
        send_item(bdq_pkg::ACT_PUSH_FRONT, 32'h7fff_ffff);
        send_item(bdq_pkg::ACT_PUSH_BACK, 32'h8000_0000);
        send_item(bdq_pkg::ACT_PUSH_FRONT, 32'h0000_0000);
        send_item(bdq_pkg::ACT_PUSH_BACK, 32'hffff_ffff);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h1234_5678);
        send_item(bdq_pkg::ACT_POP_FRONT, 32'h0000_0000);
        send_item(bdq_pkg::ACT_POP_FRONT, 32'h8000_0000);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h7fff_ffff);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h5555_5555);
        // Front pushes from an empty ring wrap the front index below zero.
        send_item(bdq_pkg::ACT_PUSH_FRONT, 32'haaaa_aaaa);
        send_item(bdq_pkg::ACT_PUSH_FRONT, 32'h5555_5555);
        send_item(bdq_pkg::ACT_PUSH_BACK, 32'h0000_0001);
        send_item(bdq_pkg::ACT_PUSH_FRONT, 32'hfffe_ffff);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h0);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h0);
        send_item(bdq_pkg::ACT_POP_FRONT, 32'h0);
        send_item(bdq_pkg::ACT_POP_BACK, 32'h0);
        send_item(bdq_pkg::ACT_POP_FRONT, 32'h0);

        send_random(180);
        wait_drained();

        send_idle_pct = 53;
        stall_pct     = 12;
        send_random(180);
        wait_drained();

        send_idle_pct = 0;
        stall_pct     = 0;
        send_random(190);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        @(negedge clk);
        if (failures == 0)
            $display("bounded_deque_tb: clean");
        else
            $display("bounded_deque_tb: errors");
        $finish;
    end

endmodule
